@@ hdl/c8_pkg.sv @@
// shared constants, types and tables for the chip-8 step core
package c8_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int ADDR_W      = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W      = $clog2(STACK_DEPTH);
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int COL_W       = $clog2(SCREEN_W);
  localparam int ROW_W       = $clog2(SCREEN_H);
  localparam int FONT_BASE   = 80;
  localparam int FONT_BYTES  = 80;
  localparam int PC_RESET    = 512;

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;

  localparam logic [7:0] FX_STORE = 8'h55;
  localparam logic [7:0] FX_LOAD  = 8'h65;
  localparam logic [7:0] FX_FONT  = 8'h29;
  localparam logic [7:0] FX_ADDI  = 8'h1E;
  localparam logic [7:0] FX_GETDT = 8'h07;
  localparam logic [7:0] FX_SETDT = 8'h15;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEB  = 4'h3;
  localparam logic [3:0] OP_SNEB = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDB  = 4'h6;
  localparam logic [3:0] OP_ADDB = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_FX   = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;

  localparam logic [3:0] VF_IDX = 4'hF;

  typedef enum logic [1:0] {
    MODE_WRITE, MODE_EXEC, MODE_TICK, MODE_ROW
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK, ST_UNKNOWN, ST_OVERFLOW
  } status_t;

  typedef enum logic {
    AOP_ADD, AOP_SUB
  } alu_op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FETCH_LO, S_DECODE, S_READ_X, S_READ_Y, S_EXEC,
    S_WRITE_X, S_RET, S_CLS, S_DRAW_RD, S_DRAW_WR, S_LOOP_RD, S_LOOP_WR,
    S_ROW, S_DONE
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] address;
    logic [7:0]  byte_value;
    logic [7:0]  random_byte;
    logic [4:0]  row_index;
  } c8_in_t;

  typedef struct packed {
    logic [11:0] pc_value;
    logic [15:0] last_instruction;
    status_t     status;
    logic [7:0]  flag_value;
    logic [7:0]  timer_value;
    logic [63:0] row_pixels;
  } c8_out_t;

  localparam logic [7:0] HEX_FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // reset contents of main memory at a given address
  function automatic logic [7:0] mem_init(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] f;
    f = a - ADDR_W'(FONT_BASE);
    if (a >= ADDR_W'(FONT_BASE) && f < ADDR_W'(FONT_BYTES)) begin
      return HEX_FONT[f[6:0]];
    end
    return 8'h00;
  endfunction

  function automatic logic [ADDR_W-1:0] font_addr(input logic [3:0] d);
    return ADDR_W'(FONT_BASE) + ADDR_W'({d, 2'b00}) + ADDR_W'(d);
  endfunction

endpackage

@@ hdl/c8_alu.sv @@
// shared 12-bit add/subtract unit with carry and borrow out
module c8_alu import c8_pkg::*; (
  input  logic [ADDR_W-1:0] a,
  input  logic [ADDR_W-1:0] b,
  input  alu_op_t           op,
  output logic [ADDR_W:0]   res
);

  // for subtract the top bit is set when a < b
  always_comb begin
    case (op)
      AOP_SUB: res = {1'b0, a} + {1'b1, ~b} + (ADDR_W+1)'(1);
      default: res = {1'b0, a} + {1'b0, b};
    endcase
  end

endmodule

@@ hdl/c8_core.sv @@
// sequencer, memories and registers of the chip-8 step core
module c8_core import c8_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  c8_in_t  in_item,
  output logic    ready,
  output logic    res_valid,
  input  logic    res_ready,
  output c8_out_t res
);

  state_t state, state_next;

  logic [ADDR_W-1:0] pc, ireg, cnt;
  logic [7:0]        timer, vf, vx, vy, hi, wb, rnd;
  logic [SP_W-1:0]   sp;
  logic [15:0]       ins;
  status_t           status;
  logic [63:0]       pix;
  logic              store;

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rf [16];
  logic [ADDR_W-1:0] stk [STACK_DEPTH];
  logic [63:0] disp [SCREEN_H];

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              rf_we;
  logic [3:0]        rf_waddr, rf_raddr;
  logic [7:0]        rf_wdata, rf_rdata;
  logic              stk_we;
  logic [SIDX_W-1:0] stk_waddr, stk_raddr;
  logic [ADDR_W-1:0] stk_rdata;
  logic              disp_we;
  logic [ROW_W-1:0]  disp_waddr, disp_raddr;
  logic [63:0]       disp_wdata, disp_rdata;

  logic [ADDR_W-1:0] alu_a, alu_b;
  alu_op_t           alu_op;
  logic [ADDR_W:0]   alu_res;

  logic [3:0]  op, x, y, n;
  logic [7:0]  nn;
  logic [SP_W-1:0]  sp_dec;
  logic [ROW_W-1:0] draw_row;
  logic [63:0] pat, mask;
  logic [127:0] rot;

  assign op = ins[15:12];
  assign x  = ins[11:8];
  assign y  = ins[7:4];
  assign n  = ins[3:0];
  assign nn = ins[7:0];
  assign sp_dec   = sp - SP_W'(1);
  assign draw_row = vy[ROW_W-1:0] + cnt[ROW_W-1:0];

  // sprite byte msb first lands at column vx, wrapping round the row
  always_comb begin
    pat = '0;
    for (int i = 0; i < 8; i++) begin
      pat[i] = mem_rdata[7-i];
    end
    rot  = {64'b0, pat} << vx[COL_W-1:0];
    mask = rot[63:0] | rot[127:64];
  end

  c8_alu u_alu (.a(alu_a), .b(alu_b), .op(alu_op), .res(alu_res));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    rf_rdata <= rf[rf_raddr];
    if (stk_we) begin
      stk[stk_waddr] <= pc;
    end
    stk_rdata <= stk[stk_raddr];
    if (disp_we) begin
      disp[disp_waddr] <= disp_wdata;
    end
    disp_rdata <= disp[disp_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (cnt == ADDR_W'(MEM_BYTES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (in_item.mode)
            MODE_EXEC: state_next = S_FETCH_LO;
            MODE_ROW:  state_next = S_ROW;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_FETCH_LO: state_next = S_DECODE;
      S_DECODE:   state_next = S_READ_X;
      S_READ_X:   state_next = S_READ_Y;
      S_READ_Y:   state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_DONE;
        case (op)
          OP_SYS: begin
            if (ins == INS_CLS) state_next = S_CLS;
            else if (ins == INS_RET && sp != '0) state_next = S_RET;
          end
          OP_ALU: if (n == ALU_ADD || n == ALU_SUB) state_next = S_WRITE_X;
          OP_DRW: if (n != 4'h0) state_next = S_DRAW_RD;
          OP_FX:  if (nn == FX_STORE || nn == FX_LOAD) state_next = S_LOOP_RD;
          default: state_next = S_DONE;
        endcase
      end
      S_WRITE_X: state_next = S_DONE;
      S_RET:     state_next = S_DONE;
      S_CLS: if (cnt[ROW_W-1:0] == ROW_W'(SCREEN_H - 1)) state_next = S_DONE;
      S_DRAW_RD: state_next = S_DRAW_WR;
      S_DRAW_WR: state_next = (cnt[3:0] + 4'd1 == n) ? S_DONE : S_DRAW_RD;
      S_LOOP_RD: state_next = S_LOOP_WR;
      S_LOOP_WR: state_next = (cnt[3:0] == x) ? S_DONE : S_LOOP_RD;
      S_ROW:     state_next = S_DONE;
      S_DONE:    if (res_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory ports and shared unit operands
  always_comb begin
    mem_we = 1'b0; mem_waddr = cnt; mem_wdata = 8'h00; mem_raddr = pc;
    rf_we = 1'b0; rf_waddr = x; rf_wdata = 8'h00; rf_raddr = x;
    stk_we = 1'b0; stk_waddr = sp[SIDX_W-1:0]; stk_raddr = sp_dec[SIDX_W-1:0];
    disp_we = 1'b0; disp_waddr = cnt[ROW_W-1:0]; disp_wdata = '0;
    disp_raddr = in_item.row_index;
    alu_a = pc; alu_b = ADDR_W'(2); alu_op = AOP_ADD;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wdata = mem_init(cnt);
        rf_we = (cnt < ADDR_W'(16));
        rf_waddr = cnt[3:0];
        disp_we = (cnt < ADDR_W'(SCREEN_H));
      end
      S_IDLE: begin
        if (start && in_item.mode == MODE_WRITE) begin
          mem_we = 1'b1;
          mem_waddr = in_item.address;
          mem_wdata = in_item.byte_value;
        end
        alu_a = ADDR_W'(timer); alu_b = ADDR_W'(1); alu_op = AOP_SUB;
      end
      S_FETCH_LO: begin
        alu_b = ADDR_W'(1);
        mem_raddr = alu_res[ADDR_W-1:0];
      end
      S_DECODE: rf_raddr = hi[3:0];
      S_READ_X: rf_raddr = y;
      S_EXEC: begin
        case (op)
          OP_CALL: stk_we = (sp < SP_W'(STACK_DEPTH));
          OP_LDB: begin rf_we = 1'b1; rf_wdata = nn; end
          OP_ADDB: begin
            alu_a = ADDR_W'(vx); alu_b = ADDR_W'(nn);
            rf_we = 1'b1; rf_wdata = alu_res[7:0];
          end
          OP_ALU: begin
            alu_a = ADDR_W'(vx); alu_b = ADDR_W'(vy);
            alu_op = (n == ALU_SUB) ? AOP_SUB : AOP_ADD;
            if (n == ALU_MOV) begin
              rf_we = 1'b1; rf_wdata = vy;
            end else if (n == ALU_ADD) begin
              rf_we = 1'b1; rf_waddr = VF_IDX; rf_wdata = {7'b0, alu_res[8]};
            end else if (n == ALU_SUB) begin
              rf_we = 1'b1; rf_waddr = VF_IDX; rf_wdata = {7'b0, ~alu_res[ADDR_W]};
            end
          end
          OP_RND: begin rf_we = 1'b1; rf_wdata = rnd & nn; end
          OP_DRW: begin rf_we = 1'b1; rf_waddr = VF_IDX; rf_wdata = 8'h00; end
          OP_FX: begin
            alu_a = ireg; alu_b = ADDR_W'(vx);
            if (nn == FX_GETDT) begin
              rf_we = 1'b1; rf_wdata = timer;
            end
          end
          default: ;
        endcase
      end
      S_WRITE_X: begin rf_we = 1'b1; rf_wdata = wb; end
      S_CLS: disp_we = 1'b1;
      S_DRAW_RD: begin
        alu_a = ireg; alu_b = cnt;
        mem_raddr = alu_res[ADDR_W-1:0];
        disp_raddr = draw_row;
      end
      S_DRAW_WR: begin
        disp_we = 1'b1;
        disp_waddr = draw_row;
        disp_wdata = disp_rdata ^ mask;
        rf_we = |(disp_rdata & mask);
        rf_waddr = VF_IDX;
        rf_wdata = 8'h01;
      end
      S_LOOP_RD: begin
        alu_a = ireg; alu_b = cnt;
        rf_raddr = cnt[3:0];
        mem_raddr = alu_res[ADDR_W-1:0];
      end
      S_LOOP_WR: begin
        alu_a = ireg; alu_b = cnt;
        if (store) begin
          mem_we = 1'b1; mem_waddr = alu_res[ADDR_W-1:0]; mem_wdata = rf_rdata;
        end else begin
          rf_we = 1'b1; rf_waddr = cnt[3:0]; rf_wdata = mem_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      pc    <= ADDR_W'(PC_RESET);
      ireg  <= '0;
      timer <= 8'h00;
      sp    <= '0;
      vf    <= 8'h00;
    end else begin
      state <= state_next;
      if (rf_we && rf_waddr == VF_IDX) vf <= rf_wdata;
      case (state)
        S_CLEAR: cnt <= cnt + ADDR_W'(1);
        S_IDLE: begin
          if (start) begin
            ins    <= 16'h0000;
            status <= ST_OK;
            pix    <= '0;
            rnd    <= in_item.random_byte;
            if (in_item.mode == MODE_TICK && timer != 8'h00) timer <= alu_res[7:0];
          end
        end
        S_FETCH_LO: hi <= mem_rdata;
        S_DECODE: begin
          ins <= {hi, mem_rdata};
          pc  <= alu_res[ADDR_W-1:0];
        end
        S_READ_X: vx <= rf_rdata;
        S_READ_Y: vy <= rf_rdata;
        S_EXEC: begin
          cnt <= '0;
          wb  <= alu_res[7:0];
          case (op)
            OP_SYS: begin
              if (ins == INS_RET) begin
                if (sp != '0) sp <= sp_dec;
              end else if (ins != INS_CLS) begin
                status <= ST_UNKNOWN;
              end
            end
            OP_JP: pc <= ins[ADDR_W-1:0];
            OP_CALL: begin
              if (sp < SP_W'(STACK_DEPTH)) begin
                sp <= sp + SP_W'(1);
                pc <= ins[ADDR_W-1:0];
              end else begin
                status <= ST_OVERFLOW;
              end
            end
            OP_SEB:  if (vx == nn) pc <= alu_res[ADDR_W-1:0];
            OP_SNEB: if (vx != nn) pc <= alu_res[ADDR_W-1:0];
            OP_SER:  if (vx == vy) pc <= alu_res[ADDR_W-1:0];
            OP_SNER: if (vx != vy) pc <= alu_res[ADDR_W-1:0];
            OP_ALU: begin
              if (n != ALU_MOV && n != ALU_ADD && n != ALU_SUB) status <= ST_UNKNOWN;
            end
            OP_LDI: ireg <= ins[ADDR_W-1:0];
            OP_FX: begin
              store <= (nn == FX_STORE);
              case (nn)
                FX_SETDT: timer <= vx;
                FX_ADDI:  ireg <= alu_res[ADDR_W-1:0];
                FX_FONT:  ireg <= font_addr(vx[3:0]);
                FX_STORE, FX_LOAD, FX_GETDT: ;
                default:  status <= ST_UNKNOWN;
              endcase
            end
            OP_LDB, OP_ADDB, OP_RND, OP_DRW: ;
            default: status <= ST_UNKNOWN;
          endcase
        end
        S_RET:     pc <= stk_rdata;
        S_CLS:     cnt <= cnt + ADDR_W'(1);
        S_DRAW_WR: cnt <= cnt + ADDR_W'(1);
        S_LOOP_WR: cnt <= cnt + ADDR_W'(1);
        S_ROW:     pix <= disp_rdata;
        default: ;
      endcase
    end
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.pc_value         = pc;
    res.last_instruction = ins;
    res.status           = status;
    res.flag_value       = vf;
    res.timer_value      = timer;
    res.row_pixels       = pix;
  end

endmodule

@@ hdl/chip8_core_step.sv @@
// top level of the chip-8 step core: stream ports and result register
// After reset the core sweeps main memory once, one byte a cycle, loading
// zeros and the hex font, taking no words. One word is then worked at a
// time, from acceptance to result: a memory write, timer tick, display
// row read, or an instruction (two byte fetches and two register reads
// through the single read port, plus a pass over the screen rows for a
// clear, a read and a write per sprite row for a draw or per register
// for FX55/FX65, or a PC reload from the stack for a return or a VX
// write for 8XY4/8XY5). PC, I and flag sums share one 12-bit adder, and
// byte memory, register file, stack and display each have one read port.
// A finished result waits in the output register while the next word runs.
module chip8_core_step import c8_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,  // mode, address, byte_value, random_byte, row_index
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata   // pc_value, last_instruction, status, flag_value,
                                 // timer_value, row_pixels
);

  c8_in_t  in_item;
  c8_out_t res;
  logic    res_valid, res_ready, core_ready;

  always_comb begin
    in_item.mode        = mode_t'(s_tdata[1:0]);
    in_item.address     = s_tdata[13:2];
    in_item.byte_value  = s_tdata[21:14];
    in_item.random_byte = s_tdata[29:22];
    in_item.row_index   = s_tdata[34:30];
  end

  assign s_tready  = core_ready;
  assign res_ready = !m_tvalid || m_tready;

  c8_core u_core (
    .clk(clk), .rst(rst), .start(s_tvalid && core_ready), .in_item(in_item),
    .ready(core_ready), .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {2'b00, res.row_pixels, res.timer_value, res.flag_value, res.status,
                  res.last_instruction, res.pc_value};
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("core still ready after taking a word");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[29:28] != 2'b11)
    else $error("undefined status code");
  a_row_no_ins: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[109:46] != 64'd0 |-> m_tdata[27:12] == 16'h0000)
    else $error("row readout carries an instruction word");
`endif

endmodule
